/* rtl/core/bsop_pkg.sv */
// ----------------------------------------------------------------------------
// bsop_pkg
// Shared constants and codes for the bounded stack with overflow policy.
// ----------------------------------------------------------------------------
package bsop_pkg;

  localparam int unsigned DefaultDepth = 8;
  localparam int unsigned DefaultWidth = 32;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_DRAIN = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    POL_DISCARD = 2'd0,
    POL_REPLACE = 2'd1,
    POL_DROP    = 2'd2
  } policy_e;

  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_EMPTY          = 3'd1,
    ST_NEW_DISCARDED  = 3'd2,
    ST_TOP_DROPPED    = 3'd3,
    ST_BOTTOM_DROPPED = 3'd4
  } status_e;

endpackage

/* rtl/core/bounded_stack_overflow_policy.sv */
// ----------------------------------------------------------------------------
// bounded_stack_overflow_policy
// LIFO stack of DEPTH words with a per-push policy for a full stack.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Push and pop give
// their single result on strobe_o in the cycle after the request, with busy
// high during that cycle, so no new request is taken while it is out. A drain
// of n items gives n results on consecutive cycles starting the cycle after
// the request (one result when empty), set by the single read port of the
// stack memory, one entry per cycle. The stack sits in a ring inside the
// memory, so dropping the bottom entry moves a base pointer instead of
// shifting data. Results cannot be held off: each is present for one cycle.
module bounded_stack_overflow_policy #(
  parameter int unsigned DEPTH = bsop_pkg::DefaultDepth,
  parameter int unsigned WIDTH = bsop_pkg::DefaultWidth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         cmd_i,
  input  logic signed [31:0] item_i,
  input  logic [1:0]         full_policy_i,
  output logic               strobe_o,
  output logic signed [31:0] value_o,
  output logic [2:0]         status_o,
  output logic [3:0]         fill_o,
  output logic               last_o
);
  import bsop_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SW    = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;
  localparam int unsigned XW    = (WIDTH > 32) ? WIDTH : 32;
  localparam int unsigned FW    = (CNT_W > 4) ? CNT_W : 4;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RESP = 2'b10
  } state_e;

  typedef enum logic [1:0] {
    SEL_ZERO = 2'd0,
    SEL_RD   = 2'd1,
    SEL_ITEM = 2'd2
  } sel_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [PTR_W-1:0] base_q, base_d;
  logic             drain_q, drain_d;
  sel_e             sel_q, sel_d;
  status_e          status_q, status_d;
  logic [WIDTH-1:0] item_q, item_d;

  logic             we, re;
  logic [PTR_W-1:0] waddr, raddr;
  logic [WIDTH-1:0] rdata;

  logic [XW-1:0]    item_x, rd_x, hold_x;
  logic [WIDTH-1:0] item_w;
  logic [FW-1:0]    fill_x;
  logic             full, empty, accept;
  logic [PTR_W-1:0] top_addr, next_addr, last_addr, base_inc;

  function automatic logic [PTR_W-1:0] wrap(input logic [SW-1:0] s);
    logic [SW-1:0] t;
    t = (s >= SW'(DEPTH)) ? s - SW'(DEPTH) : s;
    return t[PTR_W-1:0];
  endfunction

  assign item_x = XW'($unsigned(item_i));
  assign item_w = item_x[WIDTH-1:0];

  assign full   = (fill_q == CNT_W'(DEPTH));
  assign empty  = (fill_q == '0);
  assign accept = start && (state_q == S_IDLE);

  // ring positions relative to the base pointer
  assign next_addr = wrap(SW'(base_q) + SW'(fill_q));
  assign top_addr  = wrap(SW'(base_q) + SW'(fill_q) - SW'(1));
  assign last_addr = wrap(SW'(base_q) + SW'(DEPTH - 1));
  assign base_inc  = wrap(SW'(base_q) + SW'(1));

  always_comb begin
    state_d  = state_q;
    fill_d   = fill_q;
    base_d   = base_q;
    drain_d  = drain_q;
    sel_d    = sel_q;
    status_d = status_q;
    item_d   = item_q;
    we       = 1'b0;
    re       = 1'b0;
    waddr    = next_addr;
    raddr    = top_addr;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          item_d  = item_w;
          drain_d = 1'b0;
          state_d = S_RESP;
          unique case (cmd_e'(cmd_i))
            CMD_PUSH: begin
              if (!full) begin
                we       = 1'b1;
                waddr    = next_addr;
                fill_d   = fill_q + CNT_W'(1);
                status_d = ST_OK;
                sel_d    = SEL_ZERO;
              end else if (full_policy_i == POL_REPLACE) begin
                re       = 1'b1;
                raddr    = last_addr;
                we       = 1'b1;
                waddr    = last_addr;
                status_d = ST_TOP_DROPPED;
                sel_d    = SEL_RD;
              end else if (full_policy_i == POL_DROP) begin
                // old bottom slot becomes the new top; advance the base
                re       = 1'b1;
                raddr    = base_q;
                we       = 1'b1;
                waddr    = base_q;
                base_d   = base_inc;
                status_d = ST_BOTTOM_DROPPED;
                sel_d    = SEL_RD;
              end else begin
                status_d = ST_NEW_DISCARDED;
                sel_d    = SEL_ITEM;
              end
            end
            CMD_POP, CMD_DRAIN: begin
              if (empty) begin
                status_d = ST_EMPTY;
                sel_d    = SEL_ZERO;
              end else begin
                re       = 1'b1;
                raddr    = top_addr;
                fill_d   = fill_q - CNT_W'(1);
                status_d = ST_OK;
                sel_d    = SEL_RD;
                drain_d  = (cmd_e'(cmd_i) == CMD_DRAIN);
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_RESP: begin
        if (drain_q && !empty) begin
          // fetch the next entry down while this one goes out
          re     = 1'b1;
          raddr  = top_addr;
          fill_d = fill_q - CNT_W'(1);
        end else begin
          state_d = S_IDLE;
          drain_d = 1'b0;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      base_q  <= '0;
      drain_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      base_q  <= base_d;
      drain_q <= drain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q    <= sel_d;
    status_q <= status_d;
    item_q   <= item_d;
  end

  bsop_mem #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH),
    .PTR_W (PTR_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (item_w),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd_x   = XW'(rdata);
  assign hold_x = XW'(item_q);
  assign fill_x = FW'(fill_q);

  always_comb begin
    unique case (sel_q)
      SEL_RD:   value_o = $signed(rd_x[31:0]);
      SEL_ITEM: value_o = $signed(hold_x[31:0]);
      default:  value_o = '0;
    endcase
  end

  assign busy     = (state_q == S_RESP);
  assign strobe_o = (state_q == S_RESP);
  assign status_o = status_q;
  assign fill_o   = fill_x[3:0];
  assign last_o   = drain_q ? empty : 1'b1;

endmodule

/* rtl/core/bsop_mem.sv */
// ----------------------------------------------------------------------------
// bsop_mem
// Stack storage: one write port and one registered read port. A read and a
// write to the same entry in one cycle return the old contents.
// ----------------------------------------------------------------------------
module bsop_mem #(
  parameter int unsigned DEPTH = bsop_pkg::DefaultDepth,
  parameter int unsigned WIDTH = bsop_pkg::DefaultWidth,
  parameter int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [PTR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [PTR_W-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  import bsop_pkg::*;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
